>>> hdl/hcalc_pkg.sv
// Shared definitions for the hex calculator: key codes, operation codes,
// controller states and the command/status structs between control and datapath.
// No dependencies.
package hcalc_pkg;

    localparam int DATA_W = 32;
    localparam int KEY_W  = 8;

    localparam logic [DATA_W-1:0] DIGIT_LIMIT = 32'h0FFF_FFFF;
    localparam logic [DATA_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;

    localparam logic [KEY_W-1:0] KEY_BS  = 8'h08;
    localparam logic [KEY_W-1:0] KEY_ESC = 8'h1B;

    localparam logic [KEY_W-1:0] OP_EQ  = 8'h3D;
    localparam logic [KEY_W-1:0] OP_ADD = 8'h2B;
    localparam logic [KEY_W-1:0] OP_SUB = 8'h2D;
    localparam logic [KEY_W-1:0] OP_MUL = 8'h2A;
    localparam logic [KEY_W-1:0] OP_AND = 8'h26;
    localparam logic [KEY_W-1:0] OP_OR  = 8'h7C;
    localparam logic [KEY_W-1:0] OP_XOR = 8'h5E;
    localparam logic [KEY_W-1:0] OP_SHL = 8'h3C;
    localparam logic [KEY_W-1:0] OP_SHR = 8'h3E;
    localparam logic [KEY_W-1:0] OP_DIV = 8'h2F;
    localparam logic [KEY_W-1:0] OP_MOD = 8'h25;

    typedef enum logic [1:0] {
        KIND_DIGIT,
        KIND_BACKSPACE,
        KIND_ESCAPE,
        KIND_OP
    } key_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MD_START,
        ST_MD_WAIT,
        ST_OUTPUT
    } ctrl_state_t;

    typedef struct packed {
        logic load_key;
        logic md_start;
        logic exec;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        key_kind_t kind;
        logic      need_md;
        logic      md_busy;
        logic      out_free;
    } dp_status_t;

endpackage

>>> hdl/hex_calculator_keypad_alu.sv
// Top level of the 32-bit hexadecimal key-entry calculator.
// Depends on hcalc_pkg, hcalc_ctrl, hcalc_dp (which holds hcalc_muldiv).
//
//  channel   dir  tdata                 tuser
//  s_        in   [7:0] key             -
//  m_        out  [31:0] display        [0] alarm, [1] display_updated
//
// A key passes IDLE, DECIDE and OUTPUT from acceptance to the next ready; a
// pending *, / or % adds MD_START and MD_WAIT (32 shift-add/subtract iterations).
// Reset: aresetn synchronous, active low; clears number, operand, pending '='.
// Output register holds one result; a stalled m_ side holds the controller
// before handoff and so blocks the next key.
module hex_calculator_keypad_alu import hcalc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] key
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] display
    output logic [1:0]  m_tuser    // [0] alarm, [1] display_updated
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       alarm;
    logic       updated;

    hcalc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hcalc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_key     (s_tdata),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_display (m_tdata),
        .m_alarm   (alarm),
        .m_updated (updated)
    );

    assign m_tuser = {updated, alarm};

`ifndef SYNTHESIS
    a_no_key_during_md: assert property (@(posedge aclk) disable iff (!aresetn)
        status.md_busy |-> !s_tready)
        else $error("key accepted while mul/div busy");

    a_alarm_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("alarm and display_updated both set");

    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result handed off over a held transaction");

    a_md_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.md_start |=> status.md_busy)
        else $error("mul/div unit did not start");
`endif

endmodule

>>> hdl/hcalc_muldiv.sv
// Iterative 32-bit multiplier (low word) and restoring divider, one bit a cycle.
// Depends on hcalc_pkg.
module hcalc_muldiv import hcalc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              is_mul,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic              busy,
    output logic [DATA_W-1:0] hi,    // product, or remainder
    output logic [DATA_W-1:0] lo     // quotient
);

    localparam int CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    logic              busy_reg;
    logic              mul_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] hi_reg, hi_next;
    logic [DATA_W-1:0] lo_reg, lo_next;
    logic [DATA_W-1:0] opb_reg, opb_next;

    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   diff;

    always_comb begin
        rem_shift = {hi_reg, lo_reg[DATA_W-1]};
        diff      = rem_shift - {1'b0, opb_reg};
        if (mul_reg) begin
            hi_next  = lo_reg[0] ? hi_reg + opb_reg : hi_reg;
            lo_next  = {1'b0, lo_reg[DATA_W-1:1]};
            opb_next = {opb_reg[DATA_W-2:0], 1'b0};
        end else begin
            opb_next = opb_reg;
            if (!diff[DATA_W]) begin
                hi_next = diff[DATA_W-1:0];
                lo_next = {lo_reg[DATA_W-2:0], 1'b1};
            end else begin
                hi_next = rem_shift[DATA_W-1:0];
                lo_next = {lo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mul_reg <= is_mul;
            hi_reg  <= '0;
            lo_reg  <= is_mul ? b : a;
            opb_reg <= is_mul ? a : b;
        end else if (busy_reg) begin
            hi_reg  <= hi_next;
            lo_reg  <= lo_next;
            opb_reg <= opb_next;
        end
    end

    assign busy = busy_reg;
    assign hi   = hi_reg;
    assign lo   = lo_reg;

endmodule

>>> hdl/hcalc_dp.sv
// Calculator datapath: key decode, number entry, ALU and output register.
// Depends on hcalc_pkg and hcalc_muldiv.
module hcalc_dp import hcalc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    input  logic [KEY_W-1:0]  s_key,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [DATA_W-1:0] m_display,
    output logic              m_alarm,
    output logic              m_updated
);

    logic [DATA_W-1:0] cur_reg, cur_next;
    logic [DATA_W-1:0] first_reg, first_next;
    logic [KEY_W-1:0]  pend_reg, pend_next;
    logic              start_reg, start_next;
    logic [KEY_W-1:0]  key_reg;
    logic              alarm_reg, alarm_next;
    logic              upd_reg, upd_next;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_disp_reg;
    logic              out_alarm_reg;
    logic              out_upd_reg;

    logic [KEY_W-1:0]  key_fold;
    logic              is_digit;
    logic [3:0]        digit;
    key_kind_t         kind;
    logic              md_op;
    logic              md_busy;
    logic [DATA_W-1:0] md_hi, md_lo;
    logic [DATA_W-1:0] alu_res;
    logic [DATA_W-1:0] base;
    logic              big_shift;

    // lowercase letters fold to uppercase on entry
    always_comb begin
        key_fold = s_key;
        if (s_key >= 8'h61 && s_key <= 8'h7A) begin
            key_fold = s_key - 8'h20;
        end
    end

    always_comb begin
        is_digit = 1'b0;
        digit    = '0;
        if (key_reg >= 8'h30 && key_reg <= 8'h39) begin
            is_digit = 1'b1;
            digit    = 4'(key_reg - 8'h30);
        end else if (key_reg >= 8'h41 && key_reg <= 8'h46) begin
            is_digit = 1'b1;
            digit    = 4'(key_reg - 8'h37);
        end
    end

    always_comb begin
        if (key_reg == KEY_BS) begin
            kind = KIND_BACKSPACE;
        end else if (key_reg == KEY_ESC) begin
            kind = KIND_ESCAPE;
        end else if (is_digit) begin
            kind = KIND_DIGIT;
        end else begin
            kind = KIND_OP;
        end
    end

    assign md_op = (pend_reg == OP_MUL) || (pend_reg == OP_DIV) || (pend_reg == OP_MOD);

    hcalc_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.md_start),
        .is_mul  (pend_reg == OP_MUL),
        .a       (first_reg),
        .b       (cur_reg),
        .busy    (md_busy),
        .hi      (md_hi),
        .lo      (md_lo)
    );

    assign big_shift = |cur_reg[DATA_W-1:5];

    always_comb begin
        case (pend_reg)
            OP_EQ:   alu_res = cur_reg;
            OP_ADD:  alu_res = first_reg + cur_reg;
            OP_SUB:  alu_res = first_reg - cur_reg;
            OP_MUL:  alu_res = md_hi;
            OP_AND:  alu_res = first_reg & cur_reg;
            OP_OR:   alu_res = first_reg | cur_reg;
            OP_XOR:  alu_res = first_reg ^ cur_reg;
            OP_SHL:  alu_res = big_shift ? '0 : first_reg << cur_reg[4:0];
            OP_SHR:  alu_res = big_shift ? '0 : first_reg >> cur_reg[4:0];
            OP_DIV:  alu_res = (cur_reg != '0) ? md_lo : ALL_ONES;
            OP_MOD:  alu_res = (cur_reg != '0) ? md_hi : ALL_ONES;
            default: alu_res = '0;
        endcase
    end

    always_comb begin
        cur_next   = cur_reg;
        first_next = first_reg;
        pend_next  = pend_reg;
        start_next = start_reg;
        alarm_next = 1'b0;
        upd_next   = 1'b0;
        base       = start_reg ? '0 : cur_reg;
        case (kind)
            KIND_BACKSPACE: begin
                cur_next = {4'h0, cur_reg[DATA_W-1:4]};
                upd_next = 1'b1;
            end
            KIND_ESCAPE: begin
                cur_next = '0;
                upd_next = 1'b1;
            end
            KIND_DIGIT: begin
                if (start_reg) begin
                    first_next = cur_reg;
                end
                start_next = 1'b0;
                if (base <= DIGIT_LIMIT) begin
                    cur_next = {base[DATA_W-5:0], digit};
                    upd_next = 1'b1;
                end else begin
                    cur_next   = base;
                    alarm_next = 1'b1;
                end
            end
            KIND_OP: begin
                if (!start_reg) begin
                    cur_next = alu_res;
                    upd_next = 1'b1;
                end
                start_next = 1'b1;
                pend_next  = key_reg;
            end
            default: begin
                cur_next = cur_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_key) begin
            key_reg <= key_fold;
        end
        if (cmd.exec) begin
            alarm_reg <= alarm_next;
            upd_reg   <= upd_next;
        end
        if (cmd.emit) begin
            out_disp_reg  <= cur_reg;
            out_alarm_reg <= alarm_reg;
            out_upd_reg   <= upd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg   <= '0;
            first_reg <= '0;
            pend_reg  <= OP_EQ;
            start_reg <= 1'b1;
        end else if (cmd.exec) begin
            cur_reg   <= cur_next;
            first_reg <= first_next;
            pend_reg  <= pend_next;
            start_reg <= start_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.kind     = kind;
    assign status.need_md  = (kind == KIND_OP) && !start_reg && md_op;
    assign status.md_busy  = md_busy;
    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid   = out_valid_reg;
    assign m_display = out_disp_reg;
    assign m_alarm   = out_alarm_reg;
    assign m_updated = out_upd_reg;

endmodule

>>> hdl/hcalc_ctrl.sv
// Calculator controller: sequences key load, execute, mul/div wait and result handoff.
// Depends on hcalc_pkg.
module hcalc_ctrl import hcalc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = status.need_md ? ST_MD_START : ST_OUTPUT;
            end
            ST_MD_START: begin
                state_next = ST_MD_WAIT;
            end
            ST_MD_WAIT: begin
                if (!status.md_busy) begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready     = 1'b1;
                cmd.load_key = in_valid;
            end
            ST_DECIDE: begin
                cmd.exec = !status.need_md;
            end
            ST_MD_START: begin
                cmd.md_start = 1'b1;
            end
            ST_MD_WAIT: begin
                cmd.exec = !status.md_busy;
            end
            ST_OUTPUT: begin
                cmd.emit = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule
